@@ src/sls_pkg.sv @@
// Shared types and constants for the stable length sorter.
// Depends on nothing; every other file refers to it by scoped names.
package sls_pkg;

  localparam int KEY_W         = 7;    // word length field
  localparam int TAG_W         = 6;    // arrival tag field
  localparam int ARR_W         = 7;    // arrival counter
  localparam int ARR_MAX       = 127;  // arrival counter saturates here
  localparam int RESULT_LIMIT  = 64;   // most results one set can produce
  localparam int DEF_MAX_WORDS = 64;
  localparam int DEF_MAX_LEN   = 64;

  // controller -> datapath
  typedef struct packed {
    logic insert;     // store the accepted word (dropped if the row is full)
    logic pop;        // head entry taken, shift the chain toward the head
    logic clear_set;  // end of run, reset set state
  } sls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic final_entry;  // exactly one entry left
  } sls_status_t;

endpackage

@@ src/sls_ctrl.sv @@
// Controller for the stable length sorter: fill and drain sequencing.
// Depends on sls_pkg for the command and status structs.
module sls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_word,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sls_pkg::sls_status_t status,
  output sls_pkg::sls_cmd_t   cmd
);

  typedef enum logic [0:0] {
    ST_FILL,
    ST_DRAIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid & in_ready_r;
  assign out_xfer = out_valid_r & out_ready;

  assign cmd.insert    = in_xfer;
  assign cmd.pop       = out_xfer;
  assign cmd.clear_set = out_xfer & status.final_entry;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_FILL: begin
          // a last word closes the set: stop taking input, start emitting
          if (in_xfer && in_last_word) begin
            state_r     <= ST_DRAIN;
            in_ready_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        ST_DRAIN: begin
          if (out_xfer && status.final_entry) begin
            state_r     <= ST_FILL;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= ST_FILL;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ src/sls_datapath.sv @@
// Datapath for the stable length sorter: a row of key/tag cells kept in
// descending order, set counters and the overflow flag. Depends on sls_pkg.
module sls_datapath #(
  parameter int MAX_WORDS = sls_pkg::DEF_MAX_WORDS,
  parameter int MAX_LEN   = sls_pkg::DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sls_pkg::sls_cmd_t           cmd,
  input  logic [sls_pkg::KEY_W-1:0]   in_word_length,
  output sls_pkg::sls_status_t        status,
  output logic [sls_pkg::TAG_W-1:0]   out_word_index,
  output logic [sls_pkg::KEY_W-1:0]   out_sorted_length,
  output logic                        out_last_result,
  output logic                        out_overflow
);

  localparam int CAP     = (MAX_WORDS < sls_pkg::RESULT_LIMIT) ?
                           MAX_WORDS : sls_pkg::RESULT_LIMIT;
  localparam int CNT_W   = $clog2(CAP + 1);
  localparam int LEN_TOP = (MAX_LEN < 127) ? MAX_LEN : 127;
  localparam logic [sls_pkg::KEY_W-1:0] LEN_TOP_K = sls_pkg::KEY_W'(LEN_TOP);

  logic [sls_pkg::KEY_W-1:0] key_r   [CAP];
  logic [sls_pkg::KEY_W-1:0] key_nxt [CAP];
  logic [sls_pkg::TAG_W-1:0] tag_r   [CAP];
  logic [sls_pkg::TAG_W-1:0] tag_nxt [CAP];
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [sls_pkg::ARR_W-1:0] arrival_r;
  logic [sls_pkg::ARR_W-1:0] arrival_nxt;
  logic                      dropped_r;
  logic                      dropped_nxt;

  logic [sls_pkg::KEY_W-1:0] len_c;
  logic [sls_pkg::TAG_W-1:0] new_tag;
  logic                      full;
  logic                      do_store;
  logic [CAP-1:0]            ge;

  // clamp the length into 1..LEN_TOP
  always_comb begin
    if (in_word_length == '0) begin
      len_c = sls_pkg::KEY_W'(1);
    end else if (in_word_length > LEN_TOP_K) begin
      len_c = LEN_TOP_K;
    end else begin
      len_c = in_word_length;
    end
  end

  assign new_tag  = arrival_r[sls_pkg::TAG_W-1:0];
  assign full     = (count_r == CNT_W'(CAP));
  assign do_store = cmd.insert & ~full;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    // occupied cells holding an equal or longer word stay ahead of the new one
    assign ge[i] = (CNT_W'(i) < count_r) && (key_r[i] >= len_c);

    if (i == 0) begin : g_head
      always_comb begin
        key_nxt[i] = key_r[i];
        tag_nxt[i] = tag_r[i];
        if (do_store && !ge[i]) begin
          key_nxt[i] = len_c;
          tag_nxt[i] = new_tag;
        end else if (cmd.pop) begin
          if (CAP > 1) begin
            key_nxt[i] = key_r[(CAP > 1) ? 1 : 0];
            tag_nxt[i] = tag_r[(CAP > 1) ? 1 : 0];
          end
        end
      end
    end else begin : g_body
      always_comb begin
        key_nxt[i] = key_r[i];
        tag_nxt[i] = tag_r[i];
        if (do_store && !ge[i]) begin
          if (ge[i-1]) begin
            key_nxt[i] = len_c;
            tag_nxt[i] = new_tag;
          end else begin
            // shift down to make room further up
            key_nxt[i] = key_r[i-1];
            tag_nxt[i] = tag_r[i-1];
          end
        end else if (cmd.pop && (i < CAP - 1)) begin
          key_nxt[i] = key_r[(i < CAP - 1) ? i + 1 : i];
          tag_nxt[i] = tag_r[(i < CAP - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    arrival_nxt = arrival_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (arrival_r != sls_pkg::ARR_W'(sls_pkg::ARR_MAX)) begin
        arrival_nxt = arrival_r + sls_pkg::ARR_W'(1);
      end
    end
    if (cmd.clear_set) begin
      count_nxt   = '0;
      arrival_nxt = '0;
      dropped_nxt = 1'b0;
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      key_r[i] <= key_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      arrival_r <= '0;
      dropped_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      arrival_r <= arrival_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign status.final_entry = (count_r == CNT_W'(1));

  assign out_word_index    = tag_r[0];
  assign out_sorted_length = key_r[0];
  assign out_last_result   = status.final_entry;
  assign out_overflow      = dropped_r;

endmodule

@@ src/stable_length_sorter.sv @@
// Top level of the stable length sorter: controller plus cell-row datapath.
// Depends on sls_pkg, sls_ctrl and sls_datapath.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready   word_length[6:0], last_word
//   out_     output     out_valid/out_ready word_index[5:0], sorted_length[6:0],
//                                           last_result, overflow
//
// Each accepted word goes straight into its sorted place in the cell row, so one input
// transaction per cycle is taken while a set fills.
// A last word switches to emission: one result per cycle from the head cell
// while out_ready is high; in_ready is low until the run's final result is taken.
// Output stalls hold the head cell and counters; reset (rst_n, synchronous)
// clears the counters and the overflow flag, cell contents are don't-care.
module stable_length_sorter #(
  parameter int MAX_WORDS = sls_pkg::DEF_MAX_WORDS,
  parameter int MAX_LEN   = sls_pkg::DEF_MAX_LEN
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sls_pkg::KEY_W-1:0] in_word_length,
  input  logic                      in_last_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sls_pkg::TAG_W-1:0] out_word_index,
  output logic [sls_pkg::KEY_W-1:0] out_sorted_length,
  output logic                      out_last_result,
  output logic                      out_overflow
);

  sls_pkg::sls_cmd_t    cmd;
  sls_pkg::sls_status_t status;

  sls_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_word (in_last_word),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  sls_datapath #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_LEN   (MAX_LEN)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_word_length    (in_word_length),
    .status            (status),
    .out_word_index    (out_word_index),
    .out_sorted_length (out_sorted_length),
    .out_last_result   (out_last_result),
    .out_overflow      (out_overflow)
  );

endmodule
